// ===== design/wcacc_pkg.sv =====
// wcacc_pkg: shared types and constants of the weighted covariance accumulator
// item and result structs, controller states, datapath commands and status
// no dependencies
package wcacc_pkg;

	localparam int unsigned MUL_A_W   = 64;
	localparam int unsigned MUL_DIG_W = 16;
	localparam int unsigned MUL_DIGS  = 3;
	localparam int unsigned MUL_B_W   = MUL_DIG_W * MUL_DIGS;
	localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int unsigned MUL_CNT_W = 2;

	localparam int unsigned DIV_N_W   = 80;
	localparam int unsigned DIV_D_W   = 48;
	localparam int unsigned DIV_CNT_W = 7;

	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [63:0] SAT_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_NEG   = 64'h8000_0000_0000_0001;
	localparam logic [47:0] CAP_U48   = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] COV_POS   = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] COV_NEG   = 48'h8000_0000_0000;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic [16:0]        sample_weight;
		logic [16:0]        decay_factor;
		logic [31:0]        gen_tag;
	} wcacc_in_t;

	typedef struct packed {
		logic signed [31:0] mean_x;
		logic signed [31:0] mean_y;
		logic [47:0]        variance_x;
		logic [47:0]        variance_y;
		logic signed [47:0] covariance_xy;
		logic [47:0]        weight_total;
		logic [31:0]        generation_out;
	} wcacc_out_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_PROP, ST_MX, ST_MY,
		ST_XX1, ST_XX2, ST_YY1, ST_YY2, ST_XY1, ST_XY2,
		ST_DWS, ST_DXX, ST_DYY, ST_DXY,
		ST_VX, ST_VY, ST_CV, ST_EMIT
	} wcacc_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_PREP, OP_PROP, OP_MX, OP_MY,
		OP_XX1, OP_XX2, OP_YY1, OP_YY2, OP_XY1, OP_XY2,
		OP_DWS, OP_DXX, OP_DYY, OP_DXY,
		OP_VX, OP_VY, OP_CV
	} wcacc_op_t;

	typedef struct packed {
		wcacc_op_t op;
		logic      start;
		logic      wb;
		logic      load;
		logic      emit;
	} wcacc_cmd_t;

	typedef struct packed {
		logic done;
		logic w_zero;
		logic f_one;
		logic decay;
		logic out_free;
	} wcacc_stat_t;

endpackage

// ===== design/wcacc_mul.sv =====
// wcacc_mul: multi-cycle unsigned multiplier, one 16-bit digit of b per cycle
// uses wcacc_pkg
module wcacc_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [wcacc_pkg::MUL_A_W-1:0]     a,
	input  logic [wcacc_pkg::MUL_B_W-1:0]     b,
	output logic [wcacc_pkg::MUL_P_W-1:0]     p,
	output logic                              done
);
	localparam int unsigned PART_W = wcacc_pkg::MUL_A_W + wcacc_pkg::MUL_DIG_W;

	logic [wcacc_pkg::MUL_A_W-1:0]   a_q;
	logic [wcacc_pkg::MUL_B_W-1:0]   b_q;
	logic [wcacc_pkg::MUL_P_W-1:0]   acc_q;
	logic [wcacc_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [PART_W-1:0]               part;

	// most significant digit first
	assign part = PART_W'(a_q) *
		PART_W'(b_q[wcacc_pkg::MUL_B_W-1 -: wcacc_pkg::MUL_DIG_W]);
	assign p    = acc_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wcacc_pkg::MUL_CNT_W'(wcacc_pkg::MUL_DIGS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << wcacc_pkg::MUL_DIG_W) + wcacc_pkg::MUL_P_W'(part);
			b_q   <= b_q << wcacc_pkg::MUL_DIG_W;
		end
	end

endmodule

// ===== design/wcacc_div.sv =====
// wcacc_div: restoring divider, one quotient bit per cycle, result clamped to a cap
// uses wcacc_pkg
module wcacc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wcacc_pkg::DIV_N_W-1:0] dividend,
	input  logic [wcacc_pkg::DIV_D_W-1:0] divisor,
	input  logic [wcacc_pkg::DIV_D_W-1:0] cap,
	output logic [wcacc_pkg::DIV_D_W-1:0] quo,
	output logic                          done
);
	localparam int unsigned DW = wcacc_pkg::DIV_D_W;

	logic [wcacc_pkg::DIV_N_W-1:0]   n_q;
	logic [DW-1:0]                   d_q;
	logic [DW-1:0]                   cap_q;
	logic [DW-1:0]                   rem_q;
	logic [DW-1:0]                   q_q;
	logic                            ovf_q;
	logic [wcacc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [DW:0]                     rem_sh;
	logic                            ge;
	logic [DW-1:0]                   rem_nx;

	assign rem_sh = {rem_q, n_q[wcacc_pkg::DIV_N_W-1]};
	assign ge     = rem_sh >= {1'b0, d_q};
	assign rem_nx = ge ? DW'(rem_sh - {1'b0, d_q}) : rem_sh[DW-1:0];
	// bits pushed out of the quotient register mean it is past any cap
	assign quo    = (ovf_q || q_q > cap_q) ? cap_q : q_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wcacc_pkg::DIV_CNT_W'(wcacc_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			cap_q <= cap;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			rem_q <= rem_nx;
			q_q   <= {q_q[DW-2:0], ge};
			ovf_q <= ovf_q | q_q[DW-1];
		end
	end

endmodule

// ===== design/wcacc_dp.sv =====
// wcacc_dp: accumulator state, operand selection, shared multiplier and divider
// uses wcacc_pkg, wcacc_mul, wcacc_div
module wcacc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wcacc_pkg::wcacc_cmd_t cmd,
	output wcacc_pkg::wcacc_stat_t st,
	input  wcacc_pkg::wcacc_in_t  item,
	output wcacc_pkg::wcacc_out_t result,
	output logic                  result_valid,
	input  logic                  result_stall
);
	// architectural state
	logic [31:0] mean_x_q, mean_y_q;
	logic [47:0] ws_q;
	logic [63:0] mxx_q, myy_q, mxy_q;
	logic [31:0] gen_q;
	logic        out_valid_q;

	// per-item working registers
	wcacc_pkg::wcacc_in_t  in_q;
	wcacc_pkg::wcacc_out_t out_q;
	logic [16:0] w_q, f_q;
	logic [30:0] prop_q;
	logic [32:0] dxo_q, dyo_q, dxn_q, dyn_q;
	logic [47:0] t_q;
	logic [47:0] vx_q, vy_q, cv_q;

	logic [wcacc_pkg::MUL_A_W-1:0] mul_a;
	logic [wcacc_pkg::MUL_B_W-1:0] mul_b;
	logic [wcacc_pkg::MUL_P_W-1:0] mul_p;
	logic                          mul_start, mul_done;
	logic [wcacc_pkg::DIV_N_W-1:0] div_n;
	logic [47:0]                   div_cap, div_q;
	logic                          div_start, div_done;

	logic [32:0] d_cur;
	logic [31:0] m_cur;
	logic [31:0] mean_nx;
	logic [32:0] dn_nx;
	logic [47:0] r48;
	logic        inc_neg;
	logic [63:0] mom_cur, mom_acc, mom_dec;
	logic [62:0] r63;
	logic [48:0] ws_sum;
	logic [16:0] w_in, f_in;

	function automatic logic [32:0] abs33(input logic [32:0] v);
		abs33 = v[32] ? 33'(-v) : v;
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		abs64 = v[63] ? 64'(-v) : v;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (!s[64] && s[63])
			sat_add = wcacc_pkg::SAT_POS;
		else if (s[64] && (!s[63] || s[62:0] == '0))
			sat_add = wcacc_pkg::SAT_NEG;
		else
			sat_add = s[63:0];
	endfunction

	assign w_in = (item.sample_weight > wcacc_pkg::ONE_Q16) ? wcacc_pkg::ONE_Q16
		: item.sample_weight;
	assign f_in = (item.decay_factor > wcacc_pkg::ONE_Q16) ? wcacc_pkg::ONE_Q16
		: item.decay_factor;
	assign ws_sum = {1'b0, ws_q} + 49'(w_q);

	// operand selection
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_n     = '0;
		div_cap   = wcacc_pkg::CAP_U48;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (cmd.op)
			wcacc_pkg::OP_PROP: begin
				div_n     = {33'b0, w_q, 30'b0};
				div_start = cmd.start;
			end
			wcacc_pkg::OP_MX: begin
				mul_a = 64'(abs33(dxo_q)); mul_b = 48'(prop_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_MY: begin
				mul_a = 64'(abs33(dyo_q)); mul_b = 48'(prop_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_XX1: begin
				mul_a = 64'(abs33(dxo_q)); mul_b = 48'(abs33(dxn_q)); mul_start = cmd.start;
			end
			wcacc_pkg::OP_YY1: begin
				mul_a = 64'(abs33(dyo_q)); mul_b = 48'(abs33(dyn_q)); mul_start = cmd.start;
			end
			wcacc_pkg::OP_XY1: begin
				mul_a = 64'(abs33(dxo_q)); mul_b = 48'(abs33(dyn_q)); mul_start = cmd.start;
			end
			wcacc_pkg::OP_XX2, wcacc_pkg::OP_YY2, wcacc_pkg::OP_XY2: begin
				mul_a = 64'(t_q); mul_b = 48'(w_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_DWS: begin
				mul_a = 64'(ws_q); mul_b = 48'(f_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_DXX: begin
				mul_a = abs64(mxx_q); mul_b = 48'(f_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_DYY: begin
				mul_a = abs64(myy_q); mul_b = 48'(f_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_DXY: begin
				mul_a = abs64(mxy_q); mul_b = 48'(f_q); mul_start = cmd.start;
			end
			wcacc_pkg::OP_VX: begin
				div_n = {mxx_q, 16'b0}; div_start = cmd.start;
			end
			wcacc_pkg::OP_VY: begin
				div_n = {myy_q, 16'b0}; div_start = cmd.start;
			end
			wcacc_pkg::OP_CV: begin
				div_n     = {abs64(mxy_q), 16'b0};
				div_cap   = mxy_q[63] ? wcacc_pkg::COV_NEG : wcacc_pkg::COV_POS;
				div_start = cmd.start;
			end
			default: begin
			end
		endcase
	end

	// mean step, moment increment and decay scaling from the product
	always_comb begin
		d_cur   = (cmd.op == wcacc_pkg::OP_MY) ? dyo_q : dxo_q;
		m_cur   = (cmd.op == wcacc_pkg::OP_MY) ? mean_y_q : mean_x_q;
		mean_nx = d_cur[32] ? 32'({m_cur[31], m_cur[31], m_cur} - 34'(mul_p[62:30]))
			: 32'({m_cur[31], m_cur[31], m_cur} + 34'(mul_p[62:30]));
		dn_nx   = ((cmd.op == wcacc_pkg::OP_MY) ? {in_q.y_value[31], in_q.y_value}
			: {in_q.x_value[31], in_q.x_value}) - {mean_nx[31], mean_nx};
		r48     = mul_p[63:16];
		case (cmd.op)
			wcacc_pkg::OP_YY2: begin
				inc_neg = dyo_q[32] ^ dyn_q[32]; mom_cur = myy_q;
			end
			wcacc_pkg::OP_XY2: begin
				inc_neg = dxo_q[32] ^ dyn_q[32]; mom_cur = mxy_q;
			end
			wcacc_pkg::OP_DYY: begin
				inc_neg = 1'b0; mom_cur = myy_q;
			end
			wcacc_pkg::OP_DXY: begin
				inc_neg = 1'b0; mom_cur = mxy_q;
			end
			wcacc_pkg::OP_XX2: begin
				inc_neg = dxo_q[32] ^ dxn_q[32]; mom_cur = mxx_q;
			end
			default: begin
				inc_neg = 1'b0; mom_cur = mxx_q;
			end
		endcase
		mom_acc = sat_add(mom_cur, inc_neg ? 64'(-{16'b0, r48}) : {16'b0, r48});
		r63     = mul_p[78:16];
		mom_dec = mom_cur[63] ? 64'(-{1'b0, r63}) : {1'b0, r63};
	end

	wcacc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.done   (mul_done)
	);

	wcacc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (ws_q),
		.cap      (div_cap),
		.quo      (div_q),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_x_q    <= '0;
			mean_y_q    <= '0;
			ws_q        <= '0;
			mxx_q       <= '0;
			myy_q       <= '0;
			mxy_q       <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (cmd.wb) begin
				case (cmd.op)
					wcacc_pkg::OP_PREP: begin
						if (in_q.mode)
							gen_q <= in_q.gen_tag;
						else if (w_q != '0)
							ws_q <= ws_sum[48] ? wcacc_pkg::CAP_U48 : ws_sum[47:0];
					end
					wcacc_pkg::OP_MX: mean_x_q <= mean_nx;
					wcacc_pkg::OP_MY: mean_y_q <= mean_nx;
					wcacc_pkg::OP_XX2: mxx_q <= mom_acc;
					wcacc_pkg::OP_YY2: myy_q <= mom_acc;
					wcacc_pkg::OP_XY2: mxy_q <= mom_acc;
					wcacc_pkg::OP_DWS: ws_q <= mul_p[63:16];
					wcacc_pkg::OP_DXX: mxx_q <= mom_dec;
					wcacc_pkg::OP_DYY: myy_q <= mom_dec;
					wcacc_pkg::OP_DXY: mxy_q <= mom_dec;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
			w_q  <= w_in;
			f_q  <= f_in;
		end
		if (cmd.emit) begin
			out_q.mean_x         <= mean_x_q;
			out_q.mean_y         <= mean_y_q;
			out_q.variance_x     <= vx_q;
			out_q.variance_y     <= vy_q;
			out_q.covariance_xy  <= cv_q;
			out_q.weight_total   <= ws_q;
			out_q.generation_out <= gen_q;
		end
		if (cmd.wb) begin
			case (cmd.op)
				wcacc_pkg::OP_PREP: begin
					dxo_q <= {in_q.x_value[31], in_q.x_value} - {mean_x_q[31], mean_x_q};
					dyo_q <= {in_q.y_value[31], in_q.y_value} - {mean_y_q[31], mean_y_q};
				end
				wcacc_pkg::OP_PROP: prop_q <= div_q[30:0];
				wcacc_pkg::OP_MX: dxn_q <= dn_nx;
				wcacc_pkg::OP_MY: dyn_q <= dn_nx;
				wcacc_pkg::OP_XX1, wcacc_pkg::OP_YY1, wcacc_pkg::OP_XY1: t_q <= r48;
				wcacc_pkg::OP_VX:
					vx_q <= (ws_q == '0 || mxx_q[63] || mxx_q == '0) ? '0 : div_q;
				wcacc_pkg::OP_VY:
					vy_q <= (ws_q == '0 || myy_q[63] || myy_q == '0) ? '0 : div_q;
				wcacc_pkg::OP_CV:
					cv_q <= (ws_q == '0) ? '0 : (mxy_q[63] ? 48'(-div_q) : div_q);
				default: begin
				end
			endcase
		end
	end

	assign st.done     = mul_done | div_done;
	assign st.w_zero   = (w_q == '0);
	assign st.f_one    = (f_q == wcacc_pkg::ONE_Q16);
	assign st.decay    = in_q.mode;
	assign st.out_free = !out_valid_q || !result_stall;

	assign result       = out_q;
	assign result_valid = out_valid_q;

	// squared-deviation sums can only grow from zero or shrink toward it
	a_xx_nonneg: assert property (@(posedge clk) disable iff (!arst_n) !mxx_q[63])
		else $error("moment_xx went negative");
	a_yy_nonneg: assert property (@(posedge clk) disable iff (!arst_n) !myy_q[63])
		else $error("moment_yy went negative");
	a_prop_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wb && cmd.op == wcacc_pkg::OP_PROP) |=> prop_q <= wcacc_pkg::ONE_Q30)
		else $error("update proportion above one");
	a_zero_ws: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && ws_q == '0) |=> (out_q.variance_x == '0 && out_q.variance_y == '0
		&& out_q.covariance_xy == '0))
		else $error("nonzero spread with empty weight sum");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start))
		else $error("multiplier and divider started together");

endmodule

// ===== design/wcacc_ctrl.sv =====
// wcacc_ctrl: sequencer that walks one item through the datapath operations
// uses wcacc_pkg
module wcacc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  wcacc_pkg::wcacc_stat_t st,
	output wcacc_pkg::wcacc_cmd_t  cmd
);
	wcacc_pkg::wcacc_state_t state_q, state_nx;
	logic issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wcacc_pkg::ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.start)
				issued_q <= 1'b1;
			else if (cmd.wb)
				issued_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd.op     = wcacc_pkg::OP_NONE;
		cmd.start  = 1'b0;
		cmd.wb     = 1'b0;
		cmd.load   = 1'b0;
		cmd.emit   = 1'b0;
		item_stall = 1'b1;
		case (state_q)
			wcacc_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_nx = wcacc_pkg::ST_PREP;
				end
			end
			wcacc_pkg::ST_PREP: begin
				cmd.op = wcacc_pkg::OP_PREP;
				cmd.wb = 1'b1;
				if (st.decay)
					state_nx = st.f_one ? wcacc_pkg::ST_VX : wcacc_pkg::ST_DWS;
				else
					state_nx = st.w_zero ? wcacc_pkg::ST_VX : wcacc_pkg::ST_PROP;
			end
			wcacc_pkg::ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_nx = wcacc_pkg::ST_IDLE;
				end
			end
			default: begin
				// unit step: start once, write back when the unit reports done
				case (state_q)
					wcacc_pkg::ST_PROP: begin cmd.op = wcacc_pkg::OP_PROP; state_nx = wcacc_pkg::ST_MX; end
					wcacc_pkg::ST_MX:   begin cmd.op = wcacc_pkg::OP_MX;   state_nx = wcacc_pkg::ST_MY; end
					wcacc_pkg::ST_MY:   begin cmd.op = wcacc_pkg::OP_MY;   state_nx = wcacc_pkg::ST_XX1; end
					wcacc_pkg::ST_XX1:  begin cmd.op = wcacc_pkg::OP_XX1;  state_nx = wcacc_pkg::ST_XX2; end
					wcacc_pkg::ST_XX2:  begin cmd.op = wcacc_pkg::OP_XX2;  state_nx = wcacc_pkg::ST_YY1; end
					wcacc_pkg::ST_YY1:  begin cmd.op = wcacc_pkg::OP_YY1;  state_nx = wcacc_pkg::ST_YY2; end
					wcacc_pkg::ST_YY2:  begin cmd.op = wcacc_pkg::OP_YY2;  state_nx = wcacc_pkg::ST_XY1; end
					wcacc_pkg::ST_XY1:  begin cmd.op = wcacc_pkg::OP_XY1;  state_nx = wcacc_pkg::ST_XY2; end
					wcacc_pkg::ST_XY2:  begin cmd.op = wcacc_pkg::OP_XY2;  state_nx = wcacc_pkg::ST_VX; end
					wcacc_pkg::ST_DWS:  begin cmd.op = wcacc_pkg::OP_DWS;  state_nx = wcacc_pkg::ST_DXX; end
					wcacc_pkg::ST_DXX:  begin cmd.op = wcacc_pkg::OP_DXX;  state_nx = wcacc_pkg::ST_DYY; end
					wcacc_pkg::ST_DYY:  begin cmd.op = wcacc_pkg::OP_DYY;  state_nx = wcacc_pkg::ST_DXY; end
					wcacc_pkg::ST_DXY:  begin cmd.op = wcacc_pkg::OP_DXY;  state_nx = wcacc_pkg::ST_VX; end
					wcacc_pkg::ST_VX:   begin cmd.op = wcacc_pkg::OP_VX;   state_nx = wcacc_pkg::ST_VY; end
					wcacc_pkg::ST_VY:   begin cmd.op = wcacc_pkg::OP_VY;   state_nx = wcacc_pkg::ST_CV; end
					wcacc_pkg::ST_CV:   begin cmd.op = wcacc_pkg::OP_CV;   state_nx = wcacc_pkg::ST_EMIT; end
					default:            begin cmd.op = wcacc_pkg::OP_NONE; state_nx = wcacc_pkg::ST_IDLE; end
				endcase
				cmd.start = !issued_q && cmd.op != wcacc_pkg::OP_NONE;
				cmd.wb    = issued_q && st.done;
				if (!cmd.wb && cmd.op != wcacc_pkg::OP_NONE)
					state_nx = state_q;
			end
		endcase
	end

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == wcacc_pkg::ST_IDLE)
		else $error("item taken while busy");
	a_wb_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.wb)
		else $error("write back in the cycle after a unit start");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result overwritten before it was taken");

endmodule

// ===== design/weighted_covariance_accumulator_2d.sv =====
// Weighted 2-D mean and covariance accumulator. Takes one item at a time: an
// add item folds a weighted (x, y) sample into the weight sum, means and
// second-moment sums; a decay item scales the sums and stores a generation.
// Every item yields one result with means, variances, covariance, weight sum
// and generation. The work is done by a single restoring divider, which
// produces one quotient bit per cycle for an 80-bit dividend and serves the
// update proportion and the three output divides, and by a 64x48 multiplier
// that takes one 16-bit digit per cycle and is shared by the mean, moment
// and decay updates. A finished result waits in an output register while
// the next item is taken.
// uses wcacc_pkg, wcacc_ctrl, wcacc_dp
module weighted_covariance_accumulator_2d (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  wcacc_pkg::wcacc_in_t  item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output wcacc_pkg::wcacc_out_t result
);
	wcacc_pkg::wcacc_cmd_t  cmd;
	wcacc_pkg::wcacc_stat_t st;

	wcacc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	wcacc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule
